@@ rtl/particle_verlet_wall_bounce_top_macros.svh @@
// Assertion macros for the particle Verlet wall bounce block.
// Taken in by the modules that carry concurrent checks; no other dependencies.
`ifndef PARTICLE_VERLET_WALL_BOUNCE_TOP_MACROS_SVH
`define PARTICLE_VERLET_WALL_BOUNCE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PVWB_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define PVWB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pvwb_pkg.sv @@
// Shared types, constants and saturation helpers for the particle Verlet block.
// No dependencies; the four modules use it through scoped names.
package pvwb_pkg;

    // Pipeline depth in register stages, input word to output register
    localparam int PIPE_LAT = 11;
    localparam int INTEG_LAT = 4;
    localparam int BNC_LAT = 3;
    localparam int POST_WALL_LAT = 2 * BNC_LAT;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TIME_STEP   = 3'd0,
        CFG_LEFT_EDGE   = 3'd1,
        CFG_RIGHT_EDGE  = 3'd2,
        CFG_TOP_EDGE    = 3'd3,
        CFG_BOTTOM_EDGE = 3'd4
    } t_cfg_idx;

    localparam logic [15:0]        TIME_STEP_RST   = 16'd1092;
    localparam logic signed [15:0] LEFT_EDGE_RST   = 16'sd0;
    localparam logic signed [15:0] RIGHT_EDGE_RST  = 16'sd700;
    localparam logic signed [15:0] TOP_EDGE_RST    = 16'sd0;
    localparam logic signed [15:0] BOTTOM_EDGE_RST = 16'sd700;

    // Wall hit codes
    localparam logic [1:0] HIT_NONE   = 2'd0;
    localparam logic [1:0] HIT_RIGHT  = 2'd1;
    localparam logic [1:0] HIT_LEFT   = 2'd2;
    localparam logic [1:0] HIT_TOP    = 2'd1;
    localparam logic [1:0] HIT_BOTTOM = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Control that rides along with a bounce stage
    typedef struct packed {
        logic        hit;
        logic        neg_y;
        logic [16:0] rest;
    } t_bnc_ctl;

    // Registered result of the wall stage
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [1:0]         hs;
        logic [1:0]         hv;
        logic [16:0]        rest;
    } t_wall_out;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'(S32_MAX)) begin
            res = S32_MAX;
        end else if (v < 36'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Saturating negation
    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        logic signed [31:0] res;
        if (v == S32_MIN) begin
            res = S32_MAX;
        end else begin
            res = -v;
        end
        return res;
    endfunction

endpackage

@@ rtl/pvwb_item_if.sv @@
// Input channel for one particle word: valid, ready and the particle fields.
// Depends on nothing.
interface pvwb_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [8:0]         radius;
    logic [16:0]        restitution;

    modport source (
        output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, radius, restitution,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, radius, restitution,
        output ready
    );
endinterface

@@ rtl/pvwb_res_if.sv @@
// Output channel for one updated particle word: valid, ready and result fields.
// Depends on nothing.
interface pvwb_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [1:0]         hit_side;
    logic [1:0]         hit_vertical;

    modport source (
        output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, hit_side, hit_vertical,
        input  ready
    );
    modport sink (
        input  valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, hit_side, hit_vertical,
        output ready
    );
endinterface

@@ rtl/pvwb_integ.sv @@
// One axis of the velocity Verlet step as a four stage pipeline.
// Depends on pvwb_pkg (sat32).
module pvwb_integ (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_dt,
    input  logic signed [31:0] i_pos,
    input  logic signed [31:0] i_vel,
    input  logic signed [31:0] i_acc,
    output logic signed [31:0] o_pos,
    output logic signed [31:0] o_vel
);

    logic signed [17:0] w_dt;
    assign w_dt = $signed({2'b00, i_dt});

    // Stage 1: a * dt
    logic signed [48:0] r_m1, n_m1;
    logic signed [31:0] r_p1, r_v1;
    // Stage 2: half-step velocity
    logic signed [31:0] r_ha, n_ha, r_vh, n_vh, r_p2;
    logic signed [48:0] w_ha_sum;
    // Stage 3: vh * dt and final velocity
    logic signed [48:0] r_m2, n_m2;
    logic signed [31:0] r_nv3, n_nv3, r_p3;
    // Stage 4: new position
    logic signed [48:0] w_dp_sum;
    logic signed [32:0] w_dp;
    logic signed [31:0] r_np, n_np, r_nv4;

    always_comb begin
        n_m1     = 49'(i_acc * w_dt);
        // ha = rnd(a*dt, 17)
        w_ha_sum = r_m1 + 49'sd65536;
        n_ha     = w_ha_sum[48:17];
        n_vh     = pvwb_pkg::sat32(36'(r_v1) + 36'(n_ha));
        n_m2     = 49'(r_vh * w_dt);
        n_nv3    = pvwb_pkg::sat32(36'(r_vh) + 36'(r_ha));
        // p' = p + rnd(vh*dt, 16)
        w_dp_sum = r_m2 + 49'sd32768;
        w_dp     = w_dp_sum[48:16];
        n_np     = pvwb_pkg::sat32(36'(r_p3) + 36'(w_dp));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1  <= n_m1;
            r_p1  <= i_pos;
            r_v1  <= i_vel;
            r_ha  <= n_ha;
            r_vh  <= n_vh;
            r_p2  <= r_p1;
            r_m2  <= n_m2;
            r_nv3 <= n_nv3;
            r_p3  <= r_p2;
            r_np  <= n_np;
            r_nv4 <= r_nv3;
        end
    end

    assign o_pos = r_np;
    assign o_vel = r_nv4;

endmodule

@@ rtl/pvwb_wall.sv @@
// Wall test and position clamp for both axes, one register stage.
// Depends on pvwb_pkg (hit codes, t_wall_out).
module pvwb_wall (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_left,
    input  logic signed [15:0]  i_right,
    input  logic signed [15:0]  i_top,
    input  logic signed [15:0]  i_bottom,
    input  logic signed [31:0]  i_x,
    input  logic signed [31:0]  i_y,
    input  logic signed [31:0]  i_vx,
    input  logic signed [31:0]  i_vy,
    input  logic [8:0]          i_radius,
    input  logic [16:0]         i_rest,
    output pvwb_pkg::t_wall_out o_wall
);

    logic signed [33:0] w_x, w_y, w_r;
    logic signed [33:0] w_lft, w_rgt, w_top, w_bot;
    logic signed [16:0] w_rad;
    logic signed [16:0] w_cl_r, w_cl_l, w_cl_t, w_cl_b;
    pvwb_pkg::t_wall_out r_wall, n_wall;

    always_comb begin
        w_x    = 34'(i_x);
        w_y    = 34'(i_y);
        w_r    = $signed({17'b0, i_radius, 8'b0});
        w_lft  = 34'($signed({i_left, 8'b0}));
        w_rgt  = 34'($signed({i_right, 8'b0}));
        w_top  = 34'($signed({i_top, 8'b0}));
        w_bot  = 34'($signed({i_bottom, 8'b0}));
        w_rad  = $signed({8'b0, i_radius});
        // Clamp targets in whole pixels
        w_cl_r = 17'(i_right) - w_rad;
        w_cl_l = 17'(i_left) + w_rad;
        w_cl_t = 17'(i_top) + w_rad;
        w_cl_b = 17'(i_bottom) - w_rad;

        n_wall      = '0;
        n_wall.x    = i_x;
        n_wall.y    = i_y;
        n_wall.vx   = i_vx;
        n_wall.vy   = i_vy;
        n_wall.rest = i_rest;
        n_wall.hs   = pvwb_pkg::HIT_NONE;
        n_wall.hv   = pvwb_pkg::HIT_NONE;

        // Right wall wins over left
        if (w_x + w_r > w_rgt) begin
            n_wall.x  = 32'($signed({w_cl_r, 8'b0}));
            n_wall.hs = pvwb_pkg::HIT_RIGHT;
        end else if (w_x - w_r < w_lft) begin
            n_wall.x  = 32'($signed({w_cl_l, 8'b0}));
            n_wall.hs = pvwb_pkg::HIT_LEFT;
        end

        // Upper wall wins over lower
        if (w_y - w_r < w_top) begin
            n_wall.y  = 32'($signed({w_cl_t, 8'b0}));
            n_wall.hv = pvwb_pkg::HIT_TOP;
        end else if (w_y + w_r > w_bot) begin
            n_wall.y  = 32'($signed({w_cl_b, 8'b0}));
            n_wall.hv = pvwb_pkg::HIT_BOTTOM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wall <= n_wall;
        end
    end

    assign o_wall = r_wall;

endmodule

@@ rtl/pvwb_bounce.sv @@
// One bounce: on a hit, negate a velocity component, scale both by restitution.
// Three register stages. Depends on pvwb_pkg (t_bnc_ctl, sat32, neg_sat).
module pvwb_bounce (
    input  logic               i_clk,
    input  logic               i_en,
    input  pvwb_pkg::t_bnc_ctl i_ctl,
    input  logic signed [31:0] i_vx,
    input  logic signed [31:0] i_vy,
    output pvwb_pkg::t_bnc_ctl o_ctl,
    output logic signed [31:0] o_vx,
    output logic signed [31:0] o_vy
);

    pvwb_pkg::t_bnc_ctl r_a_ctl, r_b_ctl, r_c_ctl;
    logic signed [31:0] r_a_vx, r_a_vy, n_a_vx, n_a_vy;
    logic signed [31:0] r_b_vx, r_b_vy;
    logic signed [49:0] r_b_px, r_b_py, n_b_px, n_b_py;
    logic signed [17:0] w_rest;
    logic signed [49:0] w_sx, w_sy;
    logic signed [33:0] w_qx, w_qy;
    logic signed [31:0] r_c_vx, r_c_vy, n_c_vx, n_c_vy;

    always_comb begin
        // Stage A: saturating negation of the hit component
        n_a_vx = (i_ctl.hit && !i_ctl.neg_y) ? pvwb_pkg::neg_sat(i_vx) : i_vx;
        n_a_vy = (i_ctl.hit && i_ctl.neg_y) ? pvwb_pkg::neg_sat(i_vy) : i_vy;
        // Stage B: v * e
        w_rest = $signed({1'b0, r_a_ctl.rest});
        n_b_px = 50'(r_a_vx * w_rest);
        n_b_py = 50'(r_a_vy * w_rest);
        // Stage C: rnd(v*e, 16), saturate, apply only on a hit
        w_sx   = r_b_px + 50'sd32768;
        w_sy   = r_b_py + 50'sd32768;
        w_qx   = w_sx[49:16];
        w_qy   = w_sy[49:16];
        n_c_vx = r_b_ctl.hit ? pvwb_pkg::sat32(36'(w_qx)) : r_b_vx;
        n_c_vy = r_b_ctl.hit ? pvwb_pkg::sat32(36'(w_qy)) : r_b_vy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctl <= i_ctl;
            r_a_vx  <= n_a_vx;
            r_a_vy  <= n_a_vy;
            r_b_ctl <= r_a_ctl;
            r_b_vx  <= r_a_vx;
            r_b_vy  <= r_a_vy;
            r_b_px  <= n_b_px;
            r_b_py  <= n_b_py;
            r_c_ctl <= r_b_ctl;
            r_c_vx  <= n_c_vx;
            r_c_vy  <= n_c_vy;
        end
    end

    assign o_ctl = r_c_ctl;
    assign o_vx  = r_c_vx;
    assign o_vy  = r_c_vy;

endmodule

@@ rtl/particle_verlet_wall_bounce_top.sv @@
// Particle velocity Verlet step with rectangular wall bounce, top level.
// Depends on pvwb_pkg, pvwb_item_if, pvwb_res_if, pvwb_integ, pvwb_wall,
// pvwb_bounce and the assertion macro header.
//
// Usage:
//   i_item takes one particle word (position, velocity, acceleration, radius,
//   restitution) per valid/ready handshake; o_res returns one updated word
//   per input, in order. Wall and time step registers are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
//   the pipeline is empty, which the block itself does not enforce.
//   Depth: 11 register stages (4 integrate, 1 wall, 2 x 3 bounce).
//   Throughput: one word per cycle while the output is not stalled,
//   set by the single-entry issue of each stage; every multiply has a
//   register after it.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   default time step and walls.
//   When the receiver holds ready low with a result waiting, the whole
//   pipeline freezes and i_item.ready drops; nothing is lost or repeated.
//   Bubble stages keep moving while the output register is empty.
`include "particle_verlet_wall_bounce_top_macros.svh"

module particle_verlet_wall_bounce_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pvwb_item_if.sink         i_item,
    pvwb_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    localparam int LAT  = pvwb_pkg::PIPE_LAT;
    localparam int ILAT = pvwb_pkg::INTEG_LAT;
    localparam int PLAT = pvwb_pkg::POST_WALL_LAT;

    // Configuration registers
    logic [15:0]        r_dt;
    logic signed [15:0] r_left, r_right, r_top, r_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= pvwb_pkg::TIME_STEP_RST;
            r_left   <= pvwb_pkg::LEFT_EDGE_RST;
            r_right  <= pvwb_pkg::RIGHT_EDGE_RST;
            r_top    <= pvwb_pkg::TOP_EDGE_RST;
            r_bottom <= pvwb_pkg::BOTTOM_EDGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pvwb_pkg::CFG_TIME_STEP:   r_dt     <= i_cfg_data;
                pvwb_pkg::CFG_LEFT_EDGE:   r_left   <= $signed(i_cfg_data);
                pvwb_pkg::CFG_RIGHT_EDGE:  r_right  <= $signed(i_cfg_data);
                pvwb_pkg::CFG_TOP_EDGE:    r_top    <= $signed(i_cfg_data);
                pvwb_pkg::CFG_BOTTOM_EDGE: r_bottom <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Valid bits, one per stage
    logic [LAT-1:0] r_vld, n_vld;

    // Global advance: move unless the output word is stalled
    logic w_en;
    assign w_en         = !r_vld[LAT-1] || o_res.ready;
    assign i_item.ready = w_en;

    assign n_vld = {r_vld[LAT-2:0], i_item.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // Radius and restitution follow the integrate stages
    logic [8:0]  r_rad_d  [ILAT];
    logic [16:0] r_rest_d [ILAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad_d[0]  <= i_item.radius;
            r_rest_d[0] <= i_item.restitution;
            for (int i = 1; i < ILAT; i++) begin
                r_rad_d[i]  <= r_rad_d[i-1];
                r_rest_d[i] <= r_rest_d[i-1];
            end
        end
    end

    // Integrate both axes
    logic signed [31:0] w_np_x, w_np_y, w_nv_x, w_nv_y;

    pvwb_integ u_integ_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dt  (r_dt),
        .i_pos (i_item.pos_x),
        .i_vel (i_item.vel_x),
        .i_acc (i_item.acc_x),
        .o_pos (w_np_x),
        .o_vel (w_nv_x)
    );

    pvwb_integ u_integ_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dt  (r_dt),
        .i_pos (i_item.pos_y),
        .i_vel (i_item.vel_y),
        .i_acc (i_item.acc_y),
        .o_pos (w_np_y),
        .o_vel (w_nv_y)
    );

    // Wall test
    pvwb_pkg::t_wall_out w_wall;

    pvwb_wall u_wall (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_left   (r_left),
        .i_right  (r_right),
        .i_top    (r_top),
        .i_bottom (r_bottom),
        .i_x      (w_np_x),
        .i_y      (w_np_y),
        .i_vx     (w_nv_x),
        .i_vy     (w_nv_y),
        .i_radius (r_rad_d[ILAT-1]),
        .i_rest   (r_rest_d[ILAT-1]),
        .o_wall   (w_wall)
    );

    // Positions and hit codes wait for the two bounces
    logic signed [31:0] r_px_d [PLAT];
    logic signed [31:0] r_py_d [PLAT];
    logic [1:0]         r_hs_d [PLAT];
    logic [1:0]         r_hv_d [PLAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px_d[0] <= w_wall.x;
            r_py_d[0] <= w_wall.y;
            r_hs_d[0] <= w_wall.hs;
            r_hv_d[0] <= w_wall.hv;
            for (int i = 1; i < PLAT; i++) begin
                r_px_d[i] <= r_px_d[i-1];
                r_py_d[i] <= r_py_d[i-1];
                r_hs_d[i] <= r_hs_d[i-1];
                r_hv_d[i] <= r_hv_d[i-1];
            end
        end
    end

    // Side wall bounce, then vertical wall bounce
    pvwb_pkg::t_bnc_ctl w_ctl1, w_ctl1_out, w_ctl2, w_ctl2_out;
    logic signed [31:0] w_vx1, w_vy1, w_vx2, w_vy2;

    always_comb begin
        w_ctl1.hit   = (w_wall.hs != pvwb_pkg::HIT_NONE);
        w_ctl1.neg_y = 1'b0;
        w_ctl1.rest  = w_wall.rest;
        w_ctl2.hit   = (r_hv_d[pvwb_pkg::BNC_LAT-1] != pvwb_pkg::HIT_NONE);
        w_ctl2.neg_y = 1'b1;
        w_ctl2.rest  = w_ctl1_out.rest;
    end

    pvwb_bounce u_bounce_side (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ctl (w_ctl1),
        .i_vx  (w_wall.vx),
        .i_vy  (w_wall.vy),
        .o_ctl (w_ctl1_out),
        .o_vx  (w_vx1),
        .o_vy  (w_vy1)
    );

    pvwb_bounce u_bounce_vert (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ctl (w_ctl2),
        .i_vx  (w_vx1),
        .i_vy  (w_vy1),
        .o_ctl (w_ctl2_out),
        .o_vx  (w_vx2),
        .o_vy  (w_vy2)
    );

    // Result word
    assign o_res.valid        = r_vld[LAT-1];
    assign o_res.new_pos_x    = r_px_d[PLAT-1];
    assign o_res.new_pos_y    = r_py_d[PLAT-1];
    assign o_res.new_vel_x    = w_vx2;
    assign o_res.new_vel_y    = w_vy2;
    assign o_res.hit_side     = r_hs_d[PLAT-1];
    assign o_res.hit_vertical = r_hv_d[PLAT-1];

    // Checks
    `PVWB_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n,
        i_item.valid && i_item.ready, r_vld[0],
        "accepted word did not enter stage one")
    `PVWB_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n,
        o_res.valid && !o_res.ready, $stable(r_vld) && o_res.valid,
        "pipeline moved while output stalled")
    `PVWB_ASSERT_IMPL(a_side_code, i_clk, i_rst_n, o_res.valid,
        o_res.hit_side == pvwb_pkg::HIT_NONE || o_res.hit_side == pvwb_pkg::HIT_RIGHT
            || o_res.hit_side == pvwb_pkg::HIT_LEFT,
        "bad side hit code")
    `PVWB_ASSERT_IMPL(a_vert_flag, i_clk, i_rst_n, o_res.valid,
        w_ctl2_out.hit == (o_res.hit_vertical != pvwb_pkg::HIT_NONE),
        "vertical bounce flag out of step with hit code")

endmodule
